[hw/rtl/bfsa_pkg.sv]
// Shared types, constants and control structs for the best-fit segment allocator.
// Depends on nothing; every other file of the block uses it.
package bfsa_pkg;

	localparam int unsigned POOL_BYTES    = 1048576;
	localparam int unsigned GRANULE_BYTES = 32;
	localparam int unsigned HEADER_BYTES  = 24;
	localparam int unsigned MAX_SEGMENTS  = 64;

	localparam int unsigned IDX_W   = $clog2(MAX_SEGMENTS);
	localparam int unsigned LINK_W  = IDX_W + 1;
	localparam int unsigned START_W = $clog2(POOL_BYTES);
	localparam int unsigned SIZE_W  = START_W + 1;
	localparam int unsigned NEED_W  = SIZE_W + 1;
	localparam int unsigned REQ_W   = 21;
	localparam int unsigned ADDR_W  = 32;

	localparam logic [ADDR_W-1:0] POOL_BASE_RESET = 32'h0010_0000;
	localparam logic [LINK_W-1:0] SEG_END = LINK_W'(MAX_SEGMENTS);

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_ZERO    = 2'd1,
		ST_OOM     = 2'd2,
		ST_BADFREE = 2'd3
	} status_t;

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	typedef struct packed {
		logic [START_W-1:0] start;
		logic [SIZE_W-1:0]  size;
		logic [LINK_W-1:0]  link;
	} seg_row_t;

	localparam seg_row_t ROW0_RESET = '{
		start: '0,
		size:  SIZE_W'(POOL_BYTES - HEADER_BYTES),
		link:  SEG_END
	};

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_POST,
		S_WRITE_BEST,
		S_DONE
	} state_t;

	typedef struct packed {
		logic accept;
		logic scan;
		logic post;
		logic write_best;
		logic load_out;
	} bfsa_cmd_t;

	typedef struct packed {
		logic trivial;
		logic scan_last;
		logic is_free;
		logic split_go;
	} bfsa_sts_t;

endpackage

[hw/rtl/bfsa_req_if.sv]
// Request channel of the allocator: valid/ready handshake with the request payload.
// Depends on bfsa_pkg for field widths.
interface bfsa_req_if;
	logic                         valid;
	logic                         ready;
	logic                         op;
	logic [bfsa_pkg::REQ_W-1:0]   req_size;
	logic [bfsa_pkg::ADDR_W-1:0]  free_addr;

	modport source (output valid, output op, output req_size, output free_addr, input ready);
	modport sink   (input valid, input op, input req_size, input free_addr, output ready);
endinterface

[hw/rtl/bfsa_rsp_if.sv]
// Response channel of the allocator: valid/ready handshake with the result payload.
// Depends on bfsa_pkg for field widths and the status type.
interface bfsa_rsp_if;
	logic                          valid;
	logic                          ready;
	bfsa_pkg::status_t             status;
	logic [bfsa_pkg::ADDR_W-1:0]   alloc_addr;
	logic [bfsa_pkg::SIZE_W-1:0]   used_bytes;
	logic [bfsa_pkg::SIZE_W-1:0]   free_bytes;

	modport source (output valid, output status, output alloc_addr, output used_bytes,
		output free_bytes, input ready);
	modport sink   (input valid, input status, input alloc_addr, input used_bytes,
		input free_bytes, output ready);
endinterface

[hw/rtl/bfsa_ctrl.sv]
// Sequencing state machine of the allocator: handshakes and datapath commands.
// Depends on bfsa_pkg for the state type and the command/status structs.
module bfsa_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	input  logic                rsp_ready,
	output logic                rsp_valid,
	output bfsa_pkg::bfsa_cmd_t cmd,
	input  bfsa_pkg::bfsa_sts_t sts
);
	import bfsa_pkg::*;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   out_free;

	assign out_free = !out_valid_q || rsp_ready;

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (req_valid) state_d = S_SCAN;
			end
			S_SCAN: begin
				if (sts.trivial) state_d = S_DONE;
				else if (sts.scan_last) state_d = S_POST;
			end
			S_POST: begin
				if (!sts.is_free && sts.split_go) state_d = S_WRITE_BEST;
				else state_d = S_DONE;
			end
			S_WRITE_BEST: state_d = S_DONE;
			S_DONE: begin
				if (out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		req_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				req_ready  = 1'b1;
				cmd.accept = req_valid;
			end
			S_SCAN:       cmd.scan = 1'b1;
			S_POST:       cmd.post = 1'b1;
			S_WRITE_BEST: cmd.write_best = 1'b1;
			S_DONE:       cmd.load_out = out_free;
			default: begin
				cmd = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) out_valid_q <= 1'b1;
			else if (rsp_ready) out_valid_q <= 1'b0;
		end
	end

	assign rsp_valid = out_valid_q;

endmodule

[hw/rtl/bfsa_dp.sv]
// Datapath of the allocator: segment table memory, flags, scan registers, counters
// and the result register. Depends on bfsa_pkg; driven by bfsa_ctrl commands.
module bfsa_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [bfsa_pkg::ADDR_W-1:0]   cfg_wdata,
	input  logic                          in_op,
	input  logic [bfsa_pkg::REQ_W-1:0]    in_req_size,
	input  logic [bfsa_pkg::ADDR_W-1:0]   in_free_addr,
	input  bfsa_pkg::bfsa_cmd_t           cmd,
	output bfsa_pkg::bfsa_sts_t           sts,
	output bfsa_pkg::status_t             out_status,
	output logic [bfsa_pkg::ADDR_W-1:0]   out_alloc_addr,
	output logic [bfsa_pkg::SIZE_W-1:0]   out_used_bytes,
	output logic [bfsa_pkg::SIZE_W-1:0]   out_free_bytes
);
	import bfsa_pkg::*;

	seg_row_t seg_mem [MAX_SEGMENTS];
	seg_row_t rd_data_q;
	logic     dirty0_q;

	logic [ADDR_W-1:0]       pool_base_q;
	logic                    op_q;
	logic [REQ_W-1:0]        req_q;
	logic [ADDR_W-1:0]       faddr_q;
	logic [IDX_W-1:0]        step_q;
	logic [IDX_W-1:0]        rd_idx_q;
	logic [MAX_SEGMENTS-1:0] valid_q;
	logic [MAX_SEGMENTS-1:0] free_q;
	logic                    best_found_q;
	logic [IDX_W-1:0]        best_idx_q;
	seg_row_t                best_row_q;
	logic                    hit_found_q;
	logic                    hit_was_free_q;
	logic [IDX_W-1:0]        hit_idx_q;
	seg_row_t                hit_row_q;
	logic [IDX_W-1:0]        slot_q;
	logic [SIZE_W-1:0]       used_q;
	logic [SIZE_W-1:0]       freec_q;

	logic [NEED_W-1:0]       req_up;
	logic [NEED_W-1:0]       need;
	seg_row_t                row_cur;
	logic                    cur_valid;
	logic                    cur_free;
	logic [ADDR_W-1:0]       payload_cur;
	logic                    better;
	logic                    hit_now;
	logic [IDX_W-1:0]        slot;
	logic                    slot_found;
	logic                    split_ok;
	logic [IDX_W-1:0]        nx_idx;
	logic                    merge;
	logic                    rd_en;
	logic [IDX_W-1:0]        rd_addr;
	logic                    wr_en;
	logic [IDX_W-1:0]        wr_addr;
	seg_row_t                wr_row;
	logic                    free_ok;

	// Round the request up to whole granules.
	assign req_up = NEED_W'(req_q) + NEED_W'(GRANULE_BYTES - 1);
	assign need   = req_up & ~NEED_W'(GRANULE_BYTES - 1);

	// Entry 0 reads as its reset contents until it is first written.
	assign row_cur   = (rd_idx_q == '0 && !dirty0_q) ? ROW0_RESET : rd_data_q;
	assign cur_valid = valid_q[rd_idx_q];
	assign cur_free  = free_q[rd_idx_q];
	assign payload_cur = pool_base_q + ADDR_W'(row_cur.start) + ADDR_W'(HEADER_BYTES);

	assign better = cur_valid && cur_free && (NEED_W'(row_cur.size) >= need)
		&& (!best_found_q || row_cur.size < best_row_q.size);
	assign hit_now = (op_q == OP_FREE) && !hit_found_q && cur_valid && payload_cur == faddr_q;

	always_comb begin
		slot = '0;
		slot_found = 1'b0;
		for (int i = MAX_SEGMENTS - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				slot = IDX_W'(i);
				slot_found = 1'b1;
			end
		end
	end

	assign split_ok = (NEED_W'(best_row_q.size) > need + NEED_W'(HEADER_BYTES + GRANULE_BYTES));
	assign nx_idx   = hit_row_q.link[IDX_W-1:0];
	assign merge    = (hit_row_q.link < SEG_END) && valid_q[nx_idx] && free_q[nx_idx];
	assign free_ok  = hit_found_q && !hit_was_free_q;

	assign sts.trivial   = (op_q == OP_ALLOC) ? (req_q == '0) : (faddr_q == '0);
	assign sts.scan_last = (step_q == IDX_W'(MAX_SEGMENTS - 1)) || (row_cur.link >= SEG_END)
		|| hit_now;
	assign sts.is_free   = (op_q == OP_FREE);
	assign sts.split_go  = best_found_q && split_ok && slot_found;

	assign rd_en   = cmd.accept || cmd.scan;
	assign rd_addr = cmd.accept ? '0 : row_cur.link[IDX_W-1:0];

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = best_idx_q;
		wr_row  = best_row_q;
		if (cmd.post && op_q == OP_ALLOC && sts.split_go) begin
			wr_en        = 1'b1;
			wr_addr      = slot;
			wr_row.start = best_row_q.start + START_W'(HEADER_BYTES) + START_W'(need);
			wr_row.size  = best_row_q.size - SIZE_W'(need) - SIZE_W'(HEADER_BYTES);
			wr_row.link  = best_row_q.link;
		end else if (cmd.post && op_q == OP_FREE && free_ok && merge) begin
			wr_en        = 1'b1;
			wr_addr      = hit_idx_q;
			wr_row.start = hit_row_q.start;
			wr_row.size  = hit_row_q.size + row_cur.size + SIZE_W'(HEADER_BYTES);
			wr_row.link  = row_cur.link;
		end else if (cmd.write_best) begin
			wr_en        = 1'b1;
			wr_addr      = best_idx_q;
			wr_row.start = best_row_q.start;
			wr_row.size  = SIZE_W'(need);
			wr_row.link  = {1'b0, slot_q};
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) seg_mem[wr_addr] <= wr_row;
		if (rd_en) rd_data_q <= seg_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_base_q  <= POOL_BASE_RESET;
			dirty0_q     <= 1'b0;
			valid_q      <= MAX_SEGMENTS'(1);
			free_q       <= MAX_SEGMENTS'(1);
			used_q       <= '0;
			freec_q      <= SIZE_W'(POOL_BYTES);
			best_found_q <= 1'b0;
			hit_found_q  <= 1'b0;
			step_q       <= '0;
			rd_idx_q     <= '0;
		end else begin
			if (cfg_we) pool_base_q <= cfg_wdata;
			if (wr_en && wr_addr == '0) dirty0_q <= 1'b1;

			if (cmd.accept) begin
				step_q       <= '0;
				rd_idx_q     <= '0;
				best_found_q <= 1'b0;
				hit_found_q  <= 1'b0;
			end

			if (cmd.scan) begin
				step_q   <= step_q + 1'b1;
				rd_idx_q <= row_cur.link[IDX_W-1:0];
				if (op_q == OP_ALLOC && better) best_found_q <= 1'b1;
				if (hit_now) hit_found_q <= 1'b1;
			end

			if (cmd.post && op_q == OP_ALLOC && best_found_q) begin
				if (sts.split_go) begin
					valid_q[slot] <= 1'b1;
					free_q[slot]  <= 1'b1;
				end else begin
					free_q[best_idx_q] <= 1'b0;
					used_q  <= used_q + best_row_q.size + SIZE_W'(HEADER_BYTES);
					freec_q <= freec_q - best_row_q.size - SIZE_W'(HEADER_BYTES);
				end
			end

			if (cmd.post && op_q == OP_FREE && free_ok) begin
				free_q[hit_idx_q] <= 1'b1;
				used_q  <= used_q - hit_row_q.size - SIZE_W'(HEADER_BYTES);
				freec_q <= freec_q + hit_row_q.size + SIZE_W'(HEADER_BYTES);
				if (merge) begin
					valid_q[nx_idx] <= 1'b0;
					free_q[nx_idx]  <= 1'b0;
				end
			end

			if (cmd.write_best) begin
				free_q[best_idx_q] <= 1'b0;
				used_q  <= used_q + SIZE_W'(need) + SIZE_W'(HEADER_BYTES);
				freec_q <= freec_q - SIZE_W'(need) - SIZE_W'(HEADER_BYTES);
			end
		end
	end

	// Payload registers: request capture, scan candidates, the spare slot and the result.
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_q    <= in_op;
			req_q   <= in_req_size;
			faddr_q <= in_free_addr;
		end
		if (cmd.scan && op_q == OP_ALLOC && better) begin
			best_idx_q <= rd_idx_q;
			best_row_q <= row_cur;
		end
		if (cmd.scan && hit_now) begin
			hit_idx_q      <= rd_idx_q;
			hit_row_q      <= row_cur;
			hit_was_free_q <= cur_free;
		end
		if (cmd.post) slot_q <= slot;
		if (cmd.load_out) begin
			out_alloc_addr <= '0;
			out_used_bytes <= used_q;
			out_free_bytes <= freec_q;
			if (op_q == OP_ALLOC) begin
				if (req_q == '0) begin
					out_status <= ST_ZERO;
				end else if (!best_found_q) begin
					out_status <= ST_OOM;
				end else begin
					out_status     <= ST_OK;
					out_alloc_addr <= pool_base_q + ADDR_W'(best_row_q.start)
						+ ADDR_W'(HEADER_BYTES);
				end
			end else begin
				if (faddr_q == '0 || free_ok) out_status <= ST_OK;
				else out_status <= ST_BADFREE;
			end
		end
	end

endmodule

[hw/rtl/best_fit_segment_allocator.sv]
// Best-fit segment allocator: top level joining the controller and the datapath.
// An allocate or free walks the segment chain one entry per cycle (one table read per
// cycle); a zero-size allocate or a free of address zero stops at the first entry.
// Throughput: one request at a time. Reset (arst_n, asynchronous) leaves one free segment.
module best_fit_segment_allocator (
	input  logic                         clk,
	input  logic                         arst_n,
	bfsa_req_if.sink                     req,
	bfsa_rsp_if.source                   rsp,
	input  logic                         cfg_we,
	input  logic [bfsa_pkg::ADDR_W-1:0]  cfg_wdata
);
	import bfsa_pkg::*;

	// The controller walks IDLE, SCAN, POST unless trivial, WRITE_BEST for a split, and
	// DONE, where the result is loaded once the output register is free. A transaction
	// on the request side is accepted only in IDLE; the result register then decouples
	// the response side, so a waiting result does not hold up the next request's scan.
	bfsa_cmd_t cmd;
	bfsa_sts_t sts;

	bfsa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_ready (rsp.ready),
		.rsp_valid (rsp.valid),
		.cmd       (cmd),
		.sts       (sts)
	);

	// The datapath holds the segment table as a one-port-write, registered-read memory
	// of rows (offset, payload size, link), with valid and free flags in flip-flops.
	bfsa_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.in_op          (req.op),
		.in_req_size    (req.req_size),
		.in_free_addr   (req.free_addr),
		.cmd            (cmd),
		.sts            (sts),
		.out_status     (rsp.status),
		.out_alloc_addr (rsp.alloc_addr),
		.out_used_bytes (rsp.used_bytes),
		.out_free_bytes (rsp.free_bytes)
	);

endmodule
